>>> design/rfs_pkg.sv
`default_nettype none
package rfs_pkg;

   localparam logic [7:0] FRAME_LEN_BYTE  = 8'h11;
   localparam logic [6:0] MIN_FRAME_BYTES = 7'd20;
   localparam logic [7:0] INDEX_WRAP      = 8'd188;
   localparam logic [1:0] TELEM_SLOT      = 2'd2;
   localparam logic [7:0] ANT_LOSSES      = 8'd2;
   localparam logic [2:0] POWER_STRONG    = 3'd5;
   localparam logic [2:0] POWER_WEAK      = 3'd6;

   localparam int LIMIT_W        = 22;
   localparam int FIFTY_MULT     = 50;
   localparam int FAILSAFE_MULT  = 10;

   localparam logic [15:0] RST_BOUND_TX_ID   = 16'd0;
   localparam logic [15:0] RST_SYNC_BASE     = 16'd9000;
   localparam logic [7:0]  RST_MAX_MISSING   = 8'd100;
   localparam logic [15:0] RST_TELEM_DELAY   = 16'd1500;
   localparam logic [7:0]  RST_RSSI_THRESH   = 8'd110;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BOUND_TX_ID   = 3'd0,
      CSR_SYNC_BASE     = 3'd1,
      CSR_MAX_MISSING   = 3'd2,
      CSR_TELEM_DELAY   = 3'd3,
      CSR_RSSI_THRESH   = 3'd4
   } csr_index_type;

   typedef enum logic [4:0] {
      PH_STARTING  = 5'b00001,
      PH_UPDATE    = 5'b00010,
      PH_DATA      = 5'b00100,
      PH_TELEMETRY = 5'b01000,
      PH_RESUME    = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      TM_FIFTY    = 2'd0,
      TM_NORMAL   = 2'd1,
      TM_FAILSAFE = 2'd2
   } tmode_type;

   typedef struct packed {
      logic [15:0] bound_tx_id;
      logic [15:0] sync_delay_base;
      logic [7:0]  max_missing_frames;
      logic [15:0] telemetry_delay;
      logic [7:0]  power_rssi_threshold;
   } csr_type;

   typedef struct packed {
      logic [31:0] now_us;
      logic [6:0]  fifo_count;
      logic        radio_idle;
      logic [7:0]  frame_length;
      logic [15:0] frame_tx_id;
      logic [7:0]  frame_counter;
      logic        crc_ok;
      logic [7:0]  link_rssi;
   } item_type;

   typedef struct packed {
      logic       frame_accepted;
      logic       hop_and_listen;
      logic       relisten;
      logic       service_overflow;
      logic       switch_antenna;
      logic       failsafe_raise;
      logic       rssi_clear;
      logic       telemetry_prepare;
      logic       telemetry_send;
      logic [2:0] tx_power_level;
      logic [7:0] current_frame_index;
      logic [7:0] lost_frames;
   } result_type;

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
   endfunction

endpackage
`default_nettype wire

>>> design/rfs_if.sv
`default_nettype none
interface rfs_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_us;
   logic [6:0]  fifo_count;
   logic        radio_idle;
   logic [7:0]  frame_length;
   logic [15:0] frame_tx_id;
   logic [7:0]  frame_counter;
   logic        crc_ok;
   logic [7:0]  link_rssi;

   modport source (output valid, now_us, fifo_count, radio_idle, frame_length,
                   frame_tx_id, frame_counter, crc_ok, link_rssi, input ready);
   modport sink (input valid, now_us, fifo_count, radio_idle, frame_length,
                 frame_tx_id, frame_counter, crc_ok, link_rssi, output ready);
endinterface

interface rfs_rsp_if;
   logic       valid;
   logic       ready;
   logic       frame_accepted;
   logic       hop_and_listen;
   logic       relisten;
   logic       service_overflow;
   logic       switch_antenna;
   logic       failsafe_raise;
   logic       rssi_clear;
   logic       telemetry_prepare;
   logic       telemetry_send;
   logic [2:0] tx_power_level;
   logic [7:0] current_frame_index;
   logic [7:0] lost_frames;

   modport source (output valid, frame_accepted, hop_and_listen, relisten,
                   service_overflow, switch_antenna, failsafe_raise, rssi_clear,
                   telemetry_prepare, telemetry_send, tx_power_level,
                   current_frame_index, lost_frames, input ready);
   modport sink (input valid, frame_accepted, hop_and_listen, relisten,
                 service_overflow, switch_antenna, failsafe_raise, rssi_clear,
                 telemetry_prepare, telemetry_send, tx_power_level,
                 current_frame_index, lost_frames, output ready);
endinterface
`default_nettype wire

>>> design/radio_frame_sync_failsafe.sv
`default_nettype none
// Frame sync and failsafe tracker for a two-way RC receiver link. Each req
// transaction is one poll of the radio and yields exactly one rsp transaction
// carrying the actions to take (hop, relisten, antenna switch, failsafe,
// telemetry) plus the frame index and lost count after the poll. A poll is
// captured in an input register, evaluated combinationally and written into
// the result register, so the block takes one poll per clock unless rsp
// back-pressure holds it; rsp valid rises when the result register is loaded.
// rsp back-pressure stalls the input stage only when the result register is
// still occupied. Link state updates as each poll is evaluated. Configuration
// registers are written through the csr port, by the user only while no poll
// is outstanding; the block itself does not enforce this.
module radio_frame_sync_failsafe (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [rfs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [rfs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   rfs_req_if.sink                              req,
   rfs_rsp_if.source                            rsp
);
   import rfs_pkg::*;

   csr_type    csr;
   item_type   item_ff;
   logic       item_valid_ff;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       step_en;

   assign step_en   = item_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !item_valid_ff || step_en;

   rfs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .csr              (csr)
   );

   rfs_link u_link (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr),
      .item    (item_ff),
      .step_en (step_en),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req.ready) begin
            item_valid_ff <= req.valid;
         end
         if (step_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         item_ff.now_us        <= req.now_us;
         item_ff.fifo_count    <= req.fifo_count;
         item_ff.radio_idle    <= req.radio_idle;
         item_ff.frame_length  <= req.frame_length;
         item_ff.frame_tx_id   <= req.frame_tx_id;
         item_ff.frame_counter <= req.frame_counter;
         item_ff.crc_ok        <= req.crc_ok;
         item_ff.link_rssi     <= req.link_rssi;
      end
      if (step_en) begin
         rsp_ff <= result;
      end
   end

   assign rsp.valid               = rsp_valid_ff;
   assign rsp.frame_accepted      = rsp_ff.frame_accepted;
   assign rsp.hop_and_listen      = rsp_ff.hop_and_listen;
   assign rsp.relisten            = rsp_ff.relisten;
   assign rsp.service_overflow    = rsp_ff.service_overflow;
   assign rsp.switch_antenna      = rsp_ff.switch_antenna;
   assign rsp.failsafe_raise      = rsp_ff.failsafe_raise;
   assign rsp.rssi_clear          = rsp_ff.rssi_clear;
   assign rsp.telemetry_prepare   = rsp_ff.telemetry_prepare;
   assign rsp.telemetry_send      = rsp_ff.telemetry_send;
   assign rsp.tx_power_level      = rsp_ff.tx_power_level;
   assign rsp.current_frame_index = rsp_ff.current_frame_index;
   assign rsp.lost_frames         = rsp_ff.lost_frames;
endmodule
`default_nettype wire

>>> design/rfs_csr.sv
`default_nettype none
module rfs_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [rfs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [rfs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output rfs_pkg::csr_type                        csr
);
   import rfs_pkg::*;

   csr_type csr_ff;
   csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_BOUND_TX_ID: csr_in.bound_tx_id          = csr_wdata;
            CSR_SYNC_BASE:   csr_in.sync_delay_base      = csr_wdata;
            CSR_MAX_MISSING: csr_in.max_missing_frames   = csr_wdata[7:0];
            CSR_TELEM_DELAY: csr_in.telemetry_delay      = csr_wdata;
            CSR_RSSI_THRESH: csr_in.power_rssi_threshold = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.bound_tx_id          <= RST_BOUND_TX_ID;
         csr_ff.sync_delay_base      <= RST_SYNC_BASE;
         csr_ff.max_missing_frames   <= RST_MAX_MISSING;
         csr_ff.telemetry_delay      <= RST_TELEM_DELAY;
         csr_ff.power_rssi_threshold <= RST_RSSI_THRESH;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;
endmodule
`default_nettype wire

>>> design/rfs_link.sv
`default_nettype none
module rfs_link (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rfs_pkg::csr_type  csr,
   input  wire rfs_pkg::item_type item,
   input  wire logic              step_en,
   output rfs_pkg::result_type    result
);
   import rfs_pkg::*;

   phase_type   phase_ff, phase_in;
   tmode_type   mode_ff, mode_in;
   logic [31:0] lrt_ff, lrt_in;
   logic [7:0]  index_ff, index_in;
   logic [7:0]  lost_ff, lost_in;

   logic            frame_ok;
   logic [31:0]     elapsed;
   logic [31:0]     data_lrt;
   logic [31:0]     data_elapsed;
   tmode_type       data_mode;
   logic [LIMIT_W-1:0] data_limit;
   logic            data_timeout;
   logic [7:0]      data_lost;
   logic [7:0]      wrapped_index;
   logic [7:0]      synced_index;
   logic [7:0]      data_index;

   assign frame_ok = (item.fifo_count >= MIN_FRAME_BYTES)
                   && (item.frame_length == FRAME_LEN_BYTE)
                   && item.crc_ok
                   && (item.frame_tx_id == csr.bound_tx_id);

   assign elapsed = item.now_us - lrt_ff;

   // update phase and an accepted frame both restamp the receive time first
   assign data_lrt     = (phase_ff == PH_UPDATE || frame_ok) ? item.now_us : lrt_ff;
   assign data_elapsed = item.now_us - data_lrt;
   assign data_mode    = frame_ok ? TM_NORMAL : mode_ff;
   assign data_lost    = frame_ok ? 8'd0 : lost_ff;

   always_comb begin
      case (data_mode)
         TM_NORMAL:   data_limit = LIMIT_W'(csr.sync_delay_base);
         TM_FAILSAFE: data_limit = LIMIT_W'(csr.sync_delay_base)
                                   * LIMIT_W'(FAILSAFE_MULT);
         default:     data_limit = LIMIT_W'(csr.sync_delay_base)
                                   * LIMIT_W'(FIFTY_MULT);
      endcase
   end

   assign data_timeout = data_elapsed >= {{(32-LIMIT_W){1'b0}}, data_limit};

   // index resyncs to the frame counter on every accepted frame
   assign wrapped_index = (index_ff >= INDEX_WRAP) ? 8'd0 : index_ff;
   assign synced_index  = (item.frame_counter != wrapped_index) ? item.frame_counter
                                                                 : wrapped_index;
   assign data_index    = frame_ok ? sat_inc(synced_index) : index_ff;

   always_comb begin
      phase_in = phase_ff;
      mode_in  = mode_ff;
      lrt_in   = lrt_ff;
      index_in = index_ff;
      lost_in  = lost_ff;
      result   = '0;
      case (phase_ff)
         PH_RESUME: begin
            if (item.radio_idle) begin
               result.service_overflow = 1'b1;
               result.hop_and_listen   = 1'b1;
            end
            if (elapsed > {16'd0, csr.sync_delay_base}) begin
               index_in = sat_inc(index_ff);
               phase_in = PH_UPDATE;
            end
         end
         PH_TELEMETRY: begin
            if (elapsed >= {16'd0, csr.telemetry_delay}) begin
               result.telemetry_send = 1'b1;
               result.tx_power_level = (item.link_rssi > csr.power_rssi_threshold)
                                       ? POWER_STRONG : POWER_WEAK;
               phase_in = PH_RESUME;
            end
         end
         PH_UPDATE, PH_DATA: begin
            phase_in = PH_DATA;
            lrt_in   = data_lrt;
            mode_in  = data_mode;
            lost_in  = data_lost;
            index_in = data_index;
            result.service_overflow = 1'b1;
            if (frame_ok) begin
               result.frame_accepted = 1'b1;
               if (item.frame_counter[1:0] == TELEM_SLOT) begin
                  result.telemetry_prepare = 1'b1;
                  phase_in = PH_TELEMETRY;
               end else begin
                  result.relisten = 1'b1;
                  phase_in = PH_UPDATE;
               end
            end
            if (data_timeout) begin
               result.switch_antenna = data_lost >= ANT_LOSSES;
               if (data_lost >= csr.max_missing_frames) begin
                  mode_in = TM_FAILSAFE;
                  result.failsafe_raise = 1'b1;
               end
               lost_in  = sat_inc(data_lost);
               result.rssi_clear     = 1'b1;
               result.hop_and_listen = 1'b1;
               index_in = sat_inc(data_index);
               phase_in = PH_UPDATE;
               lrt_in   = item.now_us;
            end
         end
         default: begin
            result.hop_and_listen = 1'b1;
            phase_in = PH_UPDATE;
         end
      endcase
      result.current_frame_index = index_in;
      result.lost_frames         = lost_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STARTING;
         mode_ff  <= TM_FIFTY;
         lrt_ff   <= 32'd0;
         index_ff <= 8'd0;
         lost_ff  <= 8'd0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         mode_ff  <= mode_in;
         lrt_ff   <= lrt_in;
         index_ff <= index_in;
         lost_ff  <= lost_in;
      end
   end
endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
module testbench;
   import rfs_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   rfs_req_if req_bus();
   rfs_rsp_if rsp_bus();

   radio_frame_sync_failsafe dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req              (req_bus),
      .rsp              (rsp_bus)
   );

   // link tracker mirror
   csr_type     cfg;
   phase_type   link_phase;
   tmode_type   tmode;
   logic [31:0] last_rx_time;
   logic [7:0]  frame_idx;
   logic [7:0]  lost_cnt;

   result_type  results_due[$];
   result_type  due;
   logic [31:0] poll_time;
   bit          steady;

   int unsigned error_count;
   int unsigned results_seen;
   int unsigned polls_sent;
   int unsigned frames_taken;
   int unsigned telem_sent;
   int unsigned timeouts_seen;
   int unsigned failsafe_seen;
   int unsigned settings_loaded;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic logic [7:0] bump(input logic [7:0] v);
      return v + {7'd0, v != 8'hFF};
   endfunction

   // advance the mirror by one poll and return the actions it calls for
   function automatic result_type track_poll(input item_type p);
      result_type  r;
      logic [31:0] base32;
      logic [31:0] limit;
      r = '0;
      base32 = {16'd0, cfg.sync_delay_base};
      case (link_phase)
         PH_RESUME: begin
            if (p.radio_idle) begin
               r.service_overflow = 1'b1;
               r.hop_and_listen = 1'b1;
            end
            if (p.now_us - last_rx_time > base32) begin
               frame_idx = bump(frame_idx);
               link_phase = PH_UPDATE;
            end
         end
         PH_TELEMETRY: begin
            if (p.now_us - last_rx_time >= {16'd0, cfg.telemetry_delay}) begin
               r.telemetry_send = 1'b1;
               r.tx_power_level = (p.link_rssi > cfg.power_rssi_threshold) ?
                                  POWER_STRONG : POWER_WEAK;
               link_phase = PH_RESUME;
            end
         end
         PH_UPDATE, PH_DATA: begin
            if (link_phase == PH_UPDATE) begin
               link_phase = PH_DATA;
               last_rx_time = p.now_us;
            end
            if (p.fifo_count >= MIN_FRAME_BYTES && p.frame_length == FRAME_LEN_BYTE &&
                p.crc_ok && p.frame_tx_id == cfg.bound_tx_id) begin
               if (frame_idx >= INDEX_WRAP) frame_idx = 8'd0;
               if (p.frame_counter != frame_idx) frame_idx = p.frame_counter;
               r.frame_accepted = 1'b1;
               if (p.frame_counter[1:0] == TELEM_SLOT) begin
                  r.telemetry_prepare = 1'b1;
                  link_phase = PH_TELEMETRY;
               end else begin
                  r.relisten = 1'b1;
                  link_phase = PH_UPDATE;
               end
               last_rx_time = p.now_us;
               tmode = TM_NORMAL;
               lost_cnt = 8'd0;
               frame_idx = bump(frame_idx);
            end
            r.service_overflow = 1'b1;
            case (tmode)
               TM_NORMAL:   limit = base32;
               TM_FAILSAFE: limit = base32 * FAILSAFE_MULT;
               default:     limit = base32 * FIFTY_MULT;
            endcase
            if (p.now_us - last_rx_time >= limit) begin
               if (lost_cnt >= ANT_LOSSES) r.switch_antenna = 1'b1;
               if (lost_cnt >= cfg.max_missing_frames) begin
                  tmode = TM_FAILSAFE;
                  r.failsafe_raise = 1'b1;
               end
               lost_cnt = bump(lost_cnt);
               r.rssi_clear = 1'b1;
               r.hop_and_listen = 1'b1;
               frame_idx = bump(frame_idx);
               link_phase = PH_UPDATE;
               last_rx_time = p.now_us;
            end
         end
         default: begin
            r.hop_and_listen = 1'b1;
            link_phase = PH_UPDATE;
         end
      endcase
      r.current_frame_index = frame_idx;
      r.lost_frames = lost_cnt;
      return r;
   endfunction

   function automatic item_type noise_poll(input logic [31:0] t);
      item_type p;
      p.now_us = t;
      p.fifo_count = $urandom;
      p.radio_idle = $urandom;
      p.frame_length = $urandom;
      p.frame_tx_id = $urandom;
      p.frame_counter = $urandom;
      p.crc_ok = $urandom;
      p.link_rssi = $urandom;
      return p;
   endfunction

   function automatic item_type frame_poll(input logic [31:0] t, input logic [7:0] count);
      item_type p;
      p = noise_poll(t);
      p.fifo_count = $urandom_range(MIN_FRAME_BYTES, 127);
      p.frame_length = FRAME_LEN_BYTE;
      p.crc_ok = 1'b1;
      p.frame_tx_id = cfg.bound_tx_id;
      p.frame_counter = count;
      return p;
   endfunction

   function automatic item_type quiet_poll(input logic [31:0] t);
      item_type p;
      p = noise_poll(t);
      p.fifo_count = $urandom_range(0, MIN_FRAME_BYTES - 1);
      return p;
   endfunction

   // time advance scaled to the current timeouts
   function automatic logic [31:0] next_step();
      int unsigned base;
      base = cfg.sync_delay_base;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $urandom_range(0, base / 3);
         5, 6:          return $urandom_range(base / 2, 2 * base + 1);
         7:             return $urandom_range(0, cfg.telemetry_delay + 1);
         8:             return $urandom_range(base, 60 * base + 1);
         default:       return $urandom_range(0, 3);
      endcase
   endfunction

   function automatic item_type traffic_poll();
      item_type    p;
      int unsigned roll;
      logic [7:0]  in_step;
      logic [7:0]  any_cnt;
      roll = $urandom_range(0, 99);
      poll_time = poll_time + next_step();
      if (roll >= 97) poll_time = $urandom;
      in_step = (frame_idx >= INDEX_WRAP) ? 8'd0 : frame_idx;
      any_cnt = $urandom;
      if (roll < 65) begin
         p = frame_poll(poll_time, ($urandom_range(0, 9) < 7) ? in_step : any_cnt);
      end else if (roll < 80) begin
         // well-formed frame with exactly one thing wrong
         p = frame_poll(poll_time, in_step);
         case ($urandom_range(0, 3))
            0:       p.fifo_count = $urandom_range(0, MIN_FRAME_BYTES - 1);
            1:       p.frame_length = FRAME_LEN_BYTE ^ (8'd1 << $urandom_range(0, 7));
            2:       p.crc_ok = 1'b0;
            default: p.frame_tx_id = cfg.bound_tx_id ^ (16'd1 << $urandom_range(0, 15));
         endcase
      end else if (roll < 90) begin
         p = quiet_poll(poll_time);
      end else begin
         p = noise_poll(poll_time);
      end
      return p;
   endfunction

   task automatic log_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
      error_count++;
      // keep the log short
      if (error_count <= 40)
         $display("mismatch at result %0d: %s got %0h expected %0h",
                  results_seen, what, got, want);
   endtask

   task automatic send_poll(input item_type p);
      int unsigned gap;
      result_type  r;
      gap = steady ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.now_us <= p.now_us;
      req_bus.fifo_count <= p.fifo_count;
      req_bus.radio_idle <= p.radio_idle;
      req_bus.frame_length <= p.frame_length;
      req_bus.frame_tx_id <= p.frame_tx_id;
      req_bus.frame_counter <= p.frame_counter;
      req_bus.crc_ok <= p.crc_ok;
      req_bus.link_rssi <= p.link_rssi;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      r = track_poll(p);
      results_due.push_back(r);
      polls_sent++;
      frames_taken += r.frame_accepted;
      telem_sent += r.telemetry_send;
      timeouts_seen += r.rssi_clear;
      failsafe_seen += r.failsafe_raise;
   endtask

   // hold the sender until every outstanding result is back
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_settings(input csr_type c);
      drain();
      csr_write_enable <= 1'b1;
      csr_index <= CSR_BOUND_TX_ID;
      csr_wdata <= c.bound_tx_id;
      @(posedge clock);
      csr_index <= CSR_SYNC_BASE;
      csr_wdata <= c.sync_delay_base;
      @(posedge clock);
      csr_index <= CSR_MAX_MISSING;
      csr_wdata <= {8'd0, c.max_missing_frames};
      @(posedge clock);
      csr_index <= CSR_TELEM_DELAY;
      csr_wdata <= c.telemetry_delay;
      @(posedge clock);
      csr_index <= CSR_RSSI_THRESH;
      csr_wdata <= {8'd0, c.power_rssi_threshold};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg = c;
      settings_loaded++;
   endtask

   task automatic check_link_basics();
      csr_type     c;
      item_type    p;
      logic [31:0] t;
      c = {16'h5AA5, RST_SYNC_BASE, 8'd2, RST_TELEM_DELAY, RST_RSSI_THRESH};
      load_settings(c);
      send_poll(noise_poll(32'd100));
      send_poll(quiet_poll(32'd200));
      // nothing received yet, so the long startup timeout applies
      send_poll(quiet_poll(32'd450200));
      t = 32'd451000;
      p = frame_poll(t, 8'd5);
      p.fifo_count = MIN_FRAME_BYTES;
      send_poll(p);
      p = frame_poll(t + 100, 8'd6);
      p.fifo_count = MIN_FRAME_BYTES - 1;
      send_poll(p);
      p = frame_poll(t + 200, 8'd6);
      p.frame_length = FRAME_LEN_BYTE ^ 8'h01;
      send_poll(p);
      p = frame_poll(t + 300, 8'd6);
      p.crc_ok = 1'b0;
      send_poll(p);
      p = frame_poll(t + 400, 8'd6);
      p.frame_tx_id = c.bound_tx_id ^ 16'h8000;
      send_poll(p);
      p = frame_poll(t + 500, 8'd200);
      p.fifo_count = 7'd127;
      send_poll(p);
      // index is past the wrap point, restarts at zero
      send_poll(frame_poll(t + 600, 8'd0));
      t = t + 700;
      send_poll(frame_poll(t, 8'd2));
      send_poll(noise_poll(t + RST_TELEM_DELAY - 1));
      p = noise_poll(t + RST_TELEM_DELAY);
      p.link_rssi = RST_RSSI_THRESH + 1;
      send_poll(p);
      // resume leaves only when strictly more than base has passed
      p = noise_poll(t + RST_SYNC_BASE);
      p.radio_idle = 1'b1;
      send_poll(p);
      p = noise_poll(t + RST_SYNC_BASE + 1);
      p.radio_idle = 1'b1;
      send_poll(p);
      t = t + RST_SYNC_BASE + 11;
      send_poll(frame_poll(t, 8'd6));
      p = noise_poll(t + RST_TELEM_DELAY);
      p.link_rssi = RST_RSSI_THRESH;
      send_poll(p);
      p = noise_poll(t + RST_SYNC_BASE + 1);
      p.radio_idle = 1'b0;
      send_poll(p);
      t = t + RST_SYNC_BASE + 1;
      // third loss in a row switches antenna and raises failsafe
      repeat (3) begin
         send_poll(quiet_poll(t));
         t = t + RST_SYNC_BASE;
         send_poll(quiet_poll(t));
         t = t + 50;
      end
      send_poll(frame_poll(t, 8'd254));
      send_poll(noise_poll(t + RST_TELEM_DELAY));
      send_poll(noise_poll(t + RST_TELEM_DELAY + RST_SYNC_BASE));
      send_poll(noise_poll(32'hFFFF_FF00));
      send_poll(noise_poll(32'h0000_0100));
      poll_time = 32'h0000_0100;
   endtask

   task automatic run_random_traffic();
      csr_type     c;
      int unsigned k;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: c = {16'hFFFF, 16'd1, 8'd1, 16'd0, 8'd0};
            1: c = {16'h0000, 16'hFFFF, 8'd255, 16'hFFFF, 8'd255};
            2: begin
               c = {RST_BOUND_TX_ID, RST_SYNC_BASE, RST_MAX_MISSING, RST_TELEM_DELAY,
                    RST_RSSI_THRESH};
               c.bound_tx_id = $urandom;
            end
            default: begin
               c.bound_tx_id = $urandom;
               c.sync_delay_base = $urandom_range(1, 20000);
               c.max_missing_frames = $urandom_range(1, 6);
               c.telemetry_delay = $urandom_range(0, 2 * c.sync_delay_base);
               c.power_rssi_threshold = $urandom;
            end
         endcase
         load_settings(c);
         for (k = 0; k < 18; k++) begin
            if (k % 6 == 0) steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 39) == 0) drain();
            send_poll(traffic_poll());
         end
      end
      steady = 1'b0;
   endtask

   // zero base: every data poll times out, so the counters run into saturation
   task automatic run_long_outage();
      csr_type c;
      c = cfg;
      c.sync_delay_base = 16'd0;
      c.max_missing_frames = 8'd3;
      c.telemetry_delay = 16'd0;
      load_settings(c);
      repeat (260) begin
         poll_time = poll_time + $urandom_range(1, 1000);
         send_poll($urandom_range(0, 1) ? noise_poll(poll_time) : quiet_poll(poll_time));
      end
      c.max_missing_frames = 8'd0;
      load_settings(c);
      repeat (10) begin
         poll_time = poll_time + $urandom_range(1, 1000);
         send_poll(frame_poll(poll_time, $urandom));
      end
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (results_due.size() == 0) begin
            log_mismatch("result with nothing pending", 1, 0);
         end else begin
            due = results_due.pop_front();
            if (rsp_bus.frame_accepted !== due.frame_accepted)
               log_mismatch("frame_accepted", rsp_bus.frame_accepted, due.frame_accepted);
            if (rsp_bus.hop_and_listen !== due.hop_and_listen)
               log_mismatch("hop_and_listen", rsp_bus.hop_and_listen, due.hop_and_listen);
            if (rsp_bus.relisten !== due.relisten)
               log_mismatch("relisten", rsp_bus.relisten, due.relisten);
            if (rsp_bus.service_overflow !== due.service_overflow)
               log_mismatch("service_overflow", rsp_bus.service_overflow,
                            due.service_overflow);
            if (rsp_bus.switch_antenna !== due.switch_antenna)
               log_mismatch("switch_antenna", rsp_bus.switch_antenna, due.switch_antenna);
            if (rsp_bus.failsafe_raise !== due.failsafe_raise)
               log_mismatch("failsafe_raise", rsp_bus.failsafe_raise, due.failsafe_raise);
            if (rsp_bus.rssi_clear !== due.rssi_clear)
               log_mismatch("rssi_clear", rsp_bus.rssi_clear, due.rssi_clear);
            if (rsp_bus.telemetry_prepare !== due.telemetry_prepare)
               log_mismatch("telemetry_prepare", rsp_bus.telemetry_prepare,
                            due.telemetry_prepare);
            if (rsp_bus.telemetry_send !== due.telemetry_send)
               log_mismatch("telemetry_send", rsp_bus.telemetry_send, due.telemetry_send);
            if (rsp_bus.tx_power_level !== due.tx_power_level)
               log_mismatch("tx_power_level", rsp_bus.tx_power_level, due.tx_power_level);
            if (rsp_bus.current_frame_index !== due.current_frame_index)
               log_mismatch("current_frame_index", rsp_bus.current_frame_index,
                            due.current_frame_index);
            if (rsp_bus.lost_frames !== due.lost_frames)
               log_mismatch("lost_frames", rsp_bus.lost_frames, due.lost_frames);
         end
         results_seen++;
      end
   end

   // result side back-pressure
   initial begin
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 13);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   initial begin
      #2000000;
      $display("timeout with %0d results outstanding", results_due.size());
      $display("testbench: errors");
      $finish;
   end

   initial begin
      cfg = {RST_BOUND_TX_ID, RST_SYNC_BASE, RST_MAX_MISSING, RST_TELEM_DELAY,
             RST_RSSI_THRESH};
      link_phase = PH_STARTING;
      tmode = TM_FIFTY;
      last_rx_time = '0;
      frame_idx = '0;
      lost_cnt = '0;
      poll_time = '0;
      steady = 1'b0;
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_BOUND_TX_ID;
      csr_wdata <= '0;
      req_bus.valid <= 1'b0;
      req_bus.now_us <= '0;
      req_bus.fifo_count <= '0;
      req_bus.radio_idle <= 1'b0;
      req_bus.frame_length <= '0;
      req_bus.frame_tx_id <= '0;
      req_bus.frame_counter <= '0;
      req_bus.crc_ok <= 1'b0;
      req_bus.link_rssi <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      check_link_basics();
      run_random_traffic();
      run_long_outage();
      drain();
      repeat (8) @(posedge clock);
      $display("covered %0d polls under %0d settings: %0d frames taken,",
               polls_sent, settings_loaded, frames_taken);
      $display("%0d telemetry sends, %0d timeouts, %0d failsafe raises",
               telem_sent, timeouts_seen, failsafe_seen);
      if (error_count == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule

>>> files.f
design/rfs_pkg.sv
design/rfs_if.sv
design/rfs_csr.sv
design/rfs_link.sv
design/radio_frame_sync_failsafe.sv
tb/sv/testbench.sv
